@@ hdl/pwfd_pkg.sv @@
// Shared types, register map and window helpers for the pulse width frame decoder.
package pwfd_pkg;

   // Width of a measured pulse and of the received data word.
   localparam int unsigned PULSE_W     = 16;
   localparam int unsigned PAYLOAD_W   = 16;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned HEADER_W    = 3;
   localparam int unsigned NUM_HEADERS = 6;

   // Register map: one 32-bit register every four bytes.
   localparam int unsigned REG_COUNT  = 8;
   localparam int unsigned REG_IDX_W  = 3;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_HEADER0 = 0;
   localparam int unsigned REG_SHORT   = 6;
   localparam int unsigned REG_LONG    = 7;

   // One measured edge.
   typedef struct packed {
      logic                 line_level;
      logic [PULSE_W-1:0]   pulse_width;
   } req_type;

   // One decoded frame.
   typedef struct packed {
      logic [HEADER_W-1:0]  header_code;
      logic [PAYLOAD_W-1:0] payload;
      logic [3:0]           payload_bits;
      logic                 parity_ok;
   } rsp_type;

   // A width window: exclusive maximum in the upper half, exclusive minimum below.
   typedef struct packed {
      logic [PULSE_W-1:0] hi_limit;
      logic [PULSE_W-1:0] lo_limit;
   } window_type;

   // All windows as seen by the decoder.
   typedef struct packed {
      window_type [NUM_HEADERS-1:0] header_win;
      window_type                   short_win;
      window_type                   long_win;
   } cfg_type;

   // True when the width lies strictly between the window's limits.
   function automatic logic window_hit(window_type win, logic [PULSE_W-1:0] width);
      return (width > win.lo_limit) && (width < win.hi_limit);
   endfunction

endpackage

@@ hdl/pwfd_csr.sv @@
// Configuration register file holding the header and data pulse windows.
module pwfd_csr import pwfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CSR_DATA_W-1:0] regs_ff [REG_COUNT];
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = regs_ff[reg_idx];

   // Register writes complete in the access phase; all windows reset to match nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr_en) begin
         regs_ff[reg_idx] <= csr_pwdata;
      end
   end

   // Present the registers to the decoder as windows.
   always_comb begin
      for (int i = 0; i < NUM_HEADERS; i++) begin
         cfg.header_win[i] = window_type'(regs_ff[REG_HEADER0 + i]);
      end
      cfg.short_win = window_type'(regs_ff[REG_SHORT]);
      cfg.long_win  = window_type'(regs_ff[REG_LONG]);
   end

endmodule

@@ hdl/pwfd_core.sv @@
// Frame state and the per-edge decode step of the pulse width frame decoder.
module pwfd_core import pwfd_pkg::*; #(
   parameter int unsigned FRAME_LIMIT = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type item,
   input  logic    step,
   output logic    emit,
   output rsp_type result
);

   logic                 in_frame_ff, in_frame_in;
   logic                 armed_ff, armed_in;
   logic [HEADER_W-1:0]  header_ff, header_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PAYLOAD_W-1:0] data_ff, data_in;

   logic                 is_short, is_long, out_range, halt;
   logic [3:0]           last_idx;
   logic [PAYLOAD_W-1:0] pay_mask, pay;

   assign is_short  = window_hit(cfg.short_win, item.pulse_width);
   assign is_long   = window_hit(cfg.long_win, item.pulse_width);
   assign out_range = (item.pulse_width <= cfg.short_win.lo_limit) ||
                      (item.pulse_width >= cfg.long_win.hi_limit);

   // The last received bit is the parity bit; the bits below it are the payload.
   assign last_idx = 4'(count_ff - COUNT_W'(1));
   assign pay_mask = (PAYLOAD_W'(1) << last_idx) - PAYLOAD_W'(1);
   assign pay      = data_ff & pay_mask;

   assign result.header_code  = header_ff;
   assign result.payload      = pay;
   assign result.payload_bits = last_idx;
   assign result.parity_ok    = ((^pay) == data_ff[last_idx]);

   // Next state for one edge.
   always_comb begin
      in_frame_in = in_frame_ff;
      armed_in    = armed_ff;
      header_in   = header_ff;
      count_in    = count_ff;
      data_in     = data_ff;
      emit        = 1'b0;
      halt        = 1'b0;
      if (!in_frame_ff) begin
         // Hunting: a high edge restarts the bit store; the highest matching header wins.
         if (item.line_level) begin
            count_in = '0;
            data_in  = '0;
            armed_in = 1'b0;
            for (int i = 0; i < NUM_HEADERS; i++) begin
               if (window_hit(cfg.header_win[i], item.pulse_width)) begin
                  header_in   = HEADER_W'(i);
                  in_frame_in = 1'b1;
               end
            end
         end
      end else begin
         if (out_range) begin
            in_frame_in = 1'b0;
         end
         if (item.line_level) begin
            // Short high: records an armed one (aborting at the bit limit), otherwise ends a frame holding bits.
            if (is_short) begin
               if (armed_ff) begin
                  armed_in = 1'b0;
                  if (count_in >= COUNT_W'(FRAME_LIMIT)) begin
                     in_frame_in = 1'b0;
                  end else begin
                     data_in[count_in[3:0]] = 1'b1;
                     count_in = count_in + COUNT_W'(1);
                  end
               end else begin
                  if (count_ff != '0) begin
                     emit        = 1'b1;
                     in_frame_in = 1'b0;
                  end
                  halt = 1'b1;
               end
            end
            // Long high: records a zero (aborting at the bit limit), or aborts when armed.
            if (is_long && !halt) begin
               if (armed_in) begin
                  in_frame_in = 1'b0;
               end else begin
                  if (count_in >= COUNT_W'(FRAME_LIMIT)) begin
                     in_frame_in = 1'b0;
                  end else begin
                     count_in = count_in + COUNT_W'(1);
                  end
                  armed_in = 1'b0;
               end
            end
         end else begin
            // Low edges only move the arming flag, apart from the out-of-range check above.
            if (is_short) begin
               armed_in = 1'b0;
            end
            if (is_long) begin
               armed_in = 1'b1;
            end
         end
      end
   end

   // Frame state advances once per processed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         armed_ff    <= 1'b0;
         header_ff   <= '0;
         count_ff    <= '0;
         data_ff     <= '0;
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         armed_ff    <= armed_in;
         header_ff   <= header_in;
         count_ff    <= count_in;
         data_ff     <= data_in;
      end
   end

endmodule

@@ hdl/pulse_width_frame_decoder.sv @@
// Top level of the pulse width frame decoder: input register, decode step, result register.
// A word is captured in the input register and decoded there; its frame result,
// if any, is registered in the result register and shown on rsp_valid.
// Throughput: one word per cycle; the input register stalls only while a finished
// frame waits in the result register.
// Reset is synchronous: all windows clear to match nothing and the decoder hunts.
module pulse_width_frame_decoder import pwfd_pkg::*; #(
   parameter int unsigned MAX_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned FRAME_LIMIT = (MAX_BITS < PAYLOAD_W) ? MAX_BITS : PAYLOAD_W;

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff;
   rsp_type out_data_ff;
   logic    out_valid_ff;
   rsp_type result;
   logic    emit, out_free, advance;

   pwfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pwfd_core #(
      .FRAME_LIMIT (FRAME_LIMIT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_data_ff),
      .step   (advance),
      .emit   (emit),
      .result (result)
   );

   // A word moves on unless it finishes a frame while the result register is held.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ hdl/pwfd_checker.sv @@
// Port-level checks for the pulse width frame decoder, bound to the top level.
module pwfd_checker import pwfd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A held frame word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present straight after reset");

   // Reset empties the input register, so the next word is taken.
   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled straight after reset");

   // The header index comes from one of the six windows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.header_code <= HEADER_W'(NUM_HEADERS - 1))
      else $error("header code out of range");

   // No payload bit is set at or above the payload length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.payload >> rsp_data.payload_bits) == '0)
      else $error("payload bits beyond the reported length");

endmodule

bind pulse_width_frame_decoder pwfd_checker u_pwfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
